// ----- hw/rtl/ecc_pkg.sv -----
// Shared types, constants, microcode table and calendar helpers for the epoch-to-calendar clock.
package ecc_pkg;

    localparam int STEP_W = 5;
    localparam int DIVISOR_W = 17;
    localparam int DAYS_W = 16;
    localparam int YEAR_W = 12;

    typedef logic [STEP_W-1:0] step_t;

    localparam logic [1:0] REG_BASE_EPOCH = 2'd0;
    localparam logic [1:0] REG_BASE_MS = 2'd1;
    localparam logic [1:0] REG_SYNC_INTERVAL = 2'd2;

    localparam logic [31:0] SYNC_INTERVAL_RESET = 32'd3600000;

    localparam logic [DIVISOR_W-1:0] MS_PER_SEC = 17'd1000;
    localparam logic [DIVISOR_W-1:0] SECS_PER_DAY = 17'd86400;
    localparam logic [DIVISOR_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [DIVISOR_W-1:0] SECS_PER_MIN = 17'd60;
    localparam logic [DIVISOR_W-1:0] DAYS_PER_WEEK = 17'd7;

    // floor(2^32 / divisor) for each constant divisor
    localparam logic [31:0] RECIP_MS = 32'(64'h1_0000_0000 / 64'(MS_PER_SEC));
    localparam logic [31:0] RECIP_DAY = 32'(64'h1_0000_0000 / 64'(SECS_PER_DAY));
    localparam logic [31:0] RECIP_HOUR = 32'(64'h1_0000_0000 / 64'(SECS_PER_HOUR));
    localparam logic [31:0] RECIP_MIN = 32'(64'h1_0000_0000 / 64'(SECS_PER_MIN));
    localparam logic [31:0] RECIP_WEEK = 32'(64'h1_0000_0000 / 64'(DAYS_PER_WEEK));

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
    localparam logic [DAYS_W-1:0] EPOCH_WEEKDAY = 16'd4;
    // only century year in range 1970..2106 that is not a leap year
    localparam logic [YEAR_W-1:0] NONLEAP_CENTURY = 12'd2100;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ELAPSED,
        OP_DIV_MS,
        OP_EPOCH,
        OP_DIV_DAY,
        OP_DAYS,
        OP_DIV_HOUR,
        OP_HOUR,
        OP_DIV_MIN,
        OP_MINSEC,
        OP_DIV_WEEK,
        OP_WEEKDAY,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_START,
        COND_WAIT_DIV,
        COND_JUMP,
        COND_UNTIL_YEAR,
        COND_UNTIL_MONTH
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic div_busy;
        logic year_fit;
        logic month_fit;
    } stat_t;

    localparam step_t STEP_IDLE = 5'd0;
    localparam step_t STEP_YEAR = 5'd17;
    localparam step_t STEP_MONTH = 5'd18;
    localparam step_t STEP_DONE = 5'd19;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        unique case (step)
            5'd0:    w = '{op: OP_NOP,        cond: COND_START,       target: STEP_IDLE};
            5'd1:    w = '{op: OP_ELAPSED,    cond: COND_NEXT,        target: STEP_IDLE};
            5'd2:    w = '{op: OP_DIV_MS,     cond: COND_NEXT,        target: STEP_IDLE};
            5'd3:    w = '{op: OP_NOP,        cond: COND_WAIT_DIV,    target: STEP_IDLE};
            5'd4:    w = '{op: OP_EPOCH,      cond: COND_NEXT,        target: STEP_IDLE};
            5'd5:    w = '{op: OP_DIV_DAY,    cond: COND_NEXT,        target: STEP_IDLE};
            5'd6:    w = '{op: OP_NOP,        cond: COND_WAIT_DIV,    target: STEP_IDLE};
            5'd7:    w = '{op: OP_DAYS,       cond: COND_NEXT,        target: STEP_IDLE};
            5'd8:    w = '{op: OP_DIV_HOUR,   cond: COND_NEXT,        target: STEP_IDLE};
            5'd9:    w = '{op: OP_NOP,        cond: COND_WAIT_DIV,    target: STEP_IDLE};
            5'd10:   w = '{op: OP_HOUR,       cond: COND_NEXT,        target: STEP_IDLE};
            5'd11:   w = '{op: OP_DIV_MIN,    cond: COND_NEXT,        target: STEP_IDLE};
            5'd12:   w = '{op: OP_NOP,        cond: COND_WAIT_DIV,    target: STEP_IDLE};
            5'd13:   w = '{op: OP_MINSEC,     cond: COND_NEXT,        target: STEP_IDLE};
            5'd14:   w = '{op: OP_DIV_WEEK,   cond: COND_NEXT,        target: STEP_IDLE};
            5'd15:   w = '{op: OP_NOP,        cond: COND_WAIT_DIV,    target: STEP_IDLE};
            5'd16:   w = '{op: OP_WEEKDAY,    cond: COND_NEXT,        target: STEP_IDLE};
            5'd17:   w = '{op: OP_YEAR_STEP,  cond: COND_UNTIL_YEAR,  target: STEP_MONTH};
            5'd18:   w = '{op: OP_MONTH_STEP, cond: COND_UNTIL_MONTH, target: STEP_DONE};
            5'd19:   w = '{op: OP_DONE,       cond: COND_JUMP,        target: STEP_IDLE};
            default: w = '{op: OP_NOP,        cond: COND_JUMP,        target: STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month) inside
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/ecc_div.sv -----
// Constant divider by reciprocal multiplication: estimate, residue, one correction step.
module ecc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [31:0]                        dividend,
    input  logic [ecc_pkg::DIVISOR_W-1:0]      divisor,
    input  logic [31:0]                        recip,
    output logic                               busy,
    output logic [31:0]                        quot,
    output logic [ecc_pkg::DIVISOR_W-1:0]      rem
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_FIX = 2'd1;
    localparam logic [1:0] PH_RESID = 2'd2;
    localparam logic [1:0] PH_MUL = 2'd3;

    logic [1:0]                          phase_reg, phase_next;
    logic [31:0]                         num_reg, num_next;
    logic [31:0]                         recip_reg, recip_next;
    logic [ecc_pkg::DIVISOR_W-1:0]       div_reg, div_next;
    logic [31:0]                         quot_reg, quot_next;
    logic [ecc_pkg::DIVISOR_W:0]         res_reg, res_next;
    logic [31:0]                         est;
    logic [ecc_pkg::DIVISOR_W:0]         resid;
    logic                                fits;

    // recip = floor(2^32 / divisor): the estimate is the quotient or one below it
    assign est = 32'((64'(num_reg) * 64'(recip_reg)) >> 32);
    assign resid = (ecc_pkg::DIVISOR_W+1)'(num_reg - quot_reg * {15'd0, div_reg});
    assign fits = res_reg >= {1'b0, div_reg};

    always_comb
    begin
        phase_next = phase_reg;
        num_next = num_reg;
        recip_next = recip_reg;
        div_next = div_reg;
        quot_next = quot_reg;
        res_next = res_reg;
        if (start)
        begin
            phase_next = PH_MUL;
            num_next = dividend;
            recip_next = recip;
            div_next = divisor;
        end
        else
        begin
            unique case (phase_reg)
                PH_MUL:
                begin
                    quot_next = est;
                    phase_next = PH_RESID;
                end
                PH_RESID:
                begin
                    res_next = resid;
                    phase_next = PH_FIX;
                end
                PH_FIX:
                begin
                    if (fits)
                    begin
                        quot_next = quot_reg + 32'd1;
                        res_next = res_reg - {1'b0, div_reg};
                    end
                    phase_next = PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        recip_reg <= recip_next;
        div_reg <= div_next;
        quot_reg <= quot_next;
        res_reg <= res_next;
    end

    assign busy = phase_reg != PH_IDLE;
    assign quot = quot_reg;
    assign rem = res_reg[ecc_pkg::DIVISOR_W-1:0];

endmodule

// ----- hw/rtl/ecc_seq.sv -----
// Microcode sequencer: step counter, control word fetch and conditional jumps.
module ecc_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  ecc_pkg::stat_t   stat,
    output ecc_pkg::ctrl_t   ctrl,
    output logic             busy
);

    ecc_pkg::step_t pc_reg, pc_next;

    assign ctrl = ecc_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            ecc_pkg::COND_NEXT:        pc_next = pc_reg + 5'd1;
            ecc_pkg::COND_START:       pc_next = stat.start ? pc_reg + 5'd1 : pc_reg;
            ecc_pkg::COND_WAIT_DIV:    pc_next = stat.div_busy ? pc_reg : pc_reg + 5'd1;
            ecc_pkg::COND_JUMP:        pc_next = ctrl.target;
            ecc_pkg::COND_UNTIL_YEAR:  pc_next = stat.year_fit ? ctrl.target : pc_reg;
            ecc_pkg::COND_UNTIL_MONTH: pc_next = stat.month_fit ? ctrl.target : pc_reg;
            default:                   pc_next = ecc_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ecc_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign busy = pc_reg != ecc_pkg::STEP_IDLE;

endmodule

// ----- hw/rtl/epoch_to_calendar_clock_unit.sv -----
// Top level: converts a millisecond counter into time of day, Gregorian date and weekday.
//
// Usage:
//   Pulse start with now_ms while busy is low; the beat is taken at that edge.
//   busy stays high while the item is worked on; no new start is taken then.
//   The result beat appears on the output ports for exactly one cycle with
//   done high; the receiver cannot stall, so it must capture it then.
//   The time to done grows with the year and month: the work is five passes
//   of the shared constant divider (ms, day, hour, minute, weekday; each
//   pass: multiply, residue, correction), then the one-year-per-cycle and
//   one-month-per-cycle walk of the microcode loops.
//   One item at a time; a new start may be given in the done cycle.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 base_epoch,
//   1 base_ms, 2 sync_interval_ms) and cfg_data; cfg_ready is always high,
//   writes to index 3 are dropped. Write only while idle.
//   Reset: base_epoch and base_ms clear to 0, sync_interval_ms to 3600000,
//   the sequencer returns to idle and done is low.
module epoch_to_calendar_clock_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] now_ms,
    output logic        done,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute,
    output logic [11:0] cal_year,
    output logic [3:0]  cal_month,
    output logic [4:0]  cal_day,
    output logic [2:0]  weekday,
    output logic        sync_due,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] base_epoch_reg, base_ms_reg, sync_interval_reg;
    logic [31:0] now_reg;
    logic [31:0] acc_reg, acc_next;
    logic [ecc_pkg::DAYS_W-1:0] days_reg, days_next;
    logic [ecc_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [2:0]  wday_reg, wday_next;
    logic [4:0]  day_reg, day_next;
    logic        due_reg, due_next;
    logic        done_reg, done_next;

    ecc_pkg::ctrl_t ctrl;
    ecc_pkg::stat_t stat;
    logic           accept;
    logic           cfg_we;

    logic                              div_start;
    logic                              div_busy;
    logic [ecc_pkg::DIVISOR_W-1:0]     divisor;
    logic [31:0]                       recip;
    logic [31:0]                       quot;
    logic [ecc_pkg::DIVISOR_W-1:0]     rem;

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        year_fit, month_fit;
    logic [31:0] elapsed;

    assign accept = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid && cfg_ready;

    assign leap = (year_reg[1:0] == 2'b00) && (year_reg != ecc_pkg::NONLEAP_CENTURY);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = ecc_pkg::month_len(month_reg, leap);
    assign year_fit = days_reg < {7'd0, ylen};
    assign month_fit = days_reg < {11'd0, mlen};
    assign elapsed = now_reg - base_ms_reg;

    assign stat = '{start: start, div_busy: div_busy, year_fit: year_fit, month_fit: month_fit};

    ecc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    always_comb
    begin
        div_start = 1'b1;
        unique case (ctrl.op)
            ecc_pkg::OP_DIV_MS:
            begin
                divisor = ecc_pkg::MS_PER_SEC;
                recip = ecc_pkg::RECIP_MS;
            end
            ecc_pkg::OP_DIV_DAY:
            begin
                divisor = ecc_pkg::SECS_PER_DAY;
                recip = ecc_pkg::RECIP_DAY;
            end
            ecc_pkg::OP_DIV_HOUR:
            begin
                divisor = ecc_pkg::SECS_PER_HOUR;
                recip = ecc_pkg::RECIP_HOUR;
            end
            ecc_pkg::OP_DIV_MIN:
            begin
                divisor = ecc_pkg::SECS_PER_MIN;
                recip = ecc_pkg::RECIP_MIN;
            end
            ecc_pkg::OP_DIV_WEEK:
            begin
                divisor = ecc_pkg::DAYS_PER_WEEK;
                recip = ecc_pkg::RECIP_WEEK;
            end
            default:
            begin
                div_start = 1'b0;
                divisor = ecc_pkg::DAYS_PER_WEEK;
                recip = ecc_pkg::RECIP_WEEK;
            end
        endcase
    end

    ecc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (divisor),
        .recip    (recip),
        .busy     (div_busy),
        .quot     (quot),
        .rem      (rem)
    );

    always_comb
    begin
        acc_next = acc_reg;
        days_next = days_reg;
        year_next = year_reg;
        month_next = month_reg;
        hour_next = hour_reg;
        min_next = min_reg;
        sec_next = sec_reg;
        wday_next = wday_reg;
        day_next = day_reg;
        due_next = due_reg;
        done_next = 1'b0;
        unique case (ctrl.op)
            ecc_pkg::OP_ELAPSED:
            begin
                acc_next = elapsed;
                due_next = elapsed >= sync_interval_reg;
            end
            ecc_pkg::OP_EPOCH:
            begin
                acc_next = base_epoch_reg + quot;
            end
            ecc_pkg::OP_DAYS:
            begin
                days_next = quot[ecc_pkg::DAYS_W-1:0];
                acc_next = {15'd0, rem};
            end
            ecc_pkg::OP_HOUR:
            begin
                hour_next = quot[4:0];
                acc_next = {15'd0, rem};
            end
            ecc_pkg::OP_MINSEC:
            begin
                min_next = quot[5:0];
                sec_next = rem[5:0];
                acc_next = {16'd0, days_reg + ecc_pkg::EPOCH_WEEKDAY};
                year_next = ecc_pkg::EPOCH_YEAR;
                month_next = 4'd1;
            end
            ecc_pkg::OP_WEEKDAY:
            begin
                wday_next = rem[2:0];
            end
            ecc_pkg::OP_YEAR_STEP:
            begin
                if (!year_fit)
                begin
                    days_next = days_reg - {7'd0, ylen};
                    year_next = year_reg + 12'd1;
                end
            end
            ecc_pkg::OP_MONTH_STEP:
            begin
                if (!month_fit)
                begin
                    days_next = days_reg - {11'd0, mlen};
                    month_next = month_reg + 4'd1;
                end
            end
            ecc_pkg::OP_DONE:
            begin
                day_next = days_reg[4:0] + 5'd1;
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_epoch_reg <= '0;
            base_ms_reg <= '0;
            sync_interval_reg <= ecc_pkg::SYNC_INTERVAL_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ecc_pkg::REG_BASE_EPOCH:    base_epoch_reg <= cfg_data;
                    ecc_pkg::REG_BASE_MS:       base_ms_reg <= cfg_data;
                    ecc_pkg::REG_SYNC_INTERVAL: sync_interval_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= now_ms;
        end
        acc_reg <= acc_next;
        days_reg <= days_next;
        year_reg <= year_next;
        month_reg <= month_next;
        hour_reg <= hour_next;
        min_reg <= min_next;
        sec_reg <= sec_next;
        wday_reg <= wday_next;
        day_reg <= day_next;
        due_reg <= due_next;
    end

    assign done = done_reg;
    assign hour_of_day = hour_reg;
    assign minute_of_hour = min_reg;
    assign second_of_minute = sec_reg;
    assign cal_year = year_reg;
    assign cal_month = month_reg;
    assign cal_day = day_reg;
    assign weekday = wday_reg;
    assign sync_due = due_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && !div_busy)
        else $error("result strobe while still working");

    a_done_date: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cal_month >= 4'd1 && cal_month <= 4'd12 && cal_day >= 5'd1
                 && cal_day <= 5'd31 && weekday <= 3'd6)
        else $error("calendar fields out of range");

    a_done_time: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hour_of_day <= 5'd23 && minute_of_hour <= 6'd59
                 && second_of_minute <= 6'd59)
        else $error("time of day fields out of range");

endmodule
